/* hw/rtl/bgl_pkg.sv */
// Shared types and constants for the binary gcd / lcm unit.
// Used by bgl_addsub and binary_gcd_lcm_unit; no dependencies.
`timescale 1ns / 1ps

package bgl_pkg;

  localparam int unsigned IO_W           = 64;
  localparam int unsigned DATA_WIDTH_DEF = 64;

  typedef enum logic {
    OP_ADD,
    OP_SUB
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STRIP,
    ST_ODD,
    ST_LOOP,
    ST_DIV,
    ST_MUL,
    ST_DONE
  } state_e;

endpackage

/* hw/rtl/bgl_addsub.sv */
// Shared adder/subtractor of the binary gcd / lcm unit, with carry out.
// Depends on bgl_pkg for the operation code.
`timescale 1ns / 1ps

module bgl_addsub #(
  parameter int unsigned WIDTH = 65
) (
  input  logic [WIDTH-1:0] a_i,
  input  logic [WIDTH-1:0] b_i,
  input  bgl_pkg::op_e     op_i,
  output logic [WIDTH-1:0] sum_o,
  output logic             carry_o
);
  import bgl_pkg::*;

  logic             is_sub;
  logic [WIDTH-1:0] b_eff;
  logic [WIDTH:0]   full;

  assign is_sub  = (op_i == OP_SUB);
  assign b_eff   = is_sub ? ~b_i : b_i;
  // carry out is the inverted borrow when subtracting
  assign full    = {1'b0, a_i} + {1'b0, b_eff} + {{WIDTH{1'b0}}, is_sub};
  assign sum_o   = full[WIDTH-1:0];
  assign carry_o = full[WIDTH];

endmodule

/* hw/rtl/binary_gcd_lcm_unit.sv */
// Binary gcd / lcm unit: Stein gcd, then lcm = (a / gcd) * b, saturating.
// If an operand is zero, done_o rises in the cycle after accept; else the
// sequencer steps through stripping common twos, making x odd, the gcd loop,
// bitwise division, shift-add multiply and done. One shared adder.
// Busy holds through the done_o cycle, so no new item is accepted until the
// last is done; results cannot be stalled. Reset returns the sequencer to idle.
`timescale 1ns / 1ps

module binary_gcd_lcm_unit #(
  parameter int unsigned DATA_WIDTH = bgl_pkg::DATA_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [bgl_pkg::IO_W-1:0] operand_a_i,
  input  logic [bgl_pkg::IO_W-1:0] operand_b_i,
  output logic                     done_o,
  output logic [bgl_pkg::IO_W-1:0] gcd_value_o,
  output logic [bgl_pkg::IO_W-1:0] lcm_value_o,
  output logic                     lcm_overflow_o,
  output logic                     is_coprime_o
);
  import bgl_pkg::*;

  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned CW = $clog2(W);
  localparam logic [CW-1:0] CNT_LAST = CW'(W - 1);

  state_e state_q, state_d;

  logic [W-1:0]  x_q, x_d, y_q, y_d;
  logic [W-1:0]  b_q, b_d, g_q, g_d;
  logic [W-1:0]  rem_q, rem_d, quo_q, quo_d;
  logic [CW-1:0] twos_q, twos_d, cnt_q, cnt_d;
  logic          ovf_q, ovf_d;
  logic [W-1:0]  gcd_q, gcd_d, lcm_q, lcm_d;
  logic          lovf_q, lovf_d, cop_q, cop_d;

  logic [W-1:0]  a_m, b_m;
  logic          accept;
  logic          x_gt_y;
  logic [W-1:0]  g_full;
  logic [W:0]    add_a, add_b, add_sum;
  op_e           add_op;
  logic          add_co;
  logic [W:0]    div_shift;
  logic          mul_ovf;

  assign a_m    = operand_a_i[W-1:0];
  assign b_m    = operand_b_i[W-1:0];
  assign accept = start && !busy;
  assign x_gt_y = x_q > y_q;
  assign g_full = x_q << twos_q;
  assign div_shift = {rem_q, quo_q[W-1]};

  bgl_addsub #(
    .WIDTH (W + 1)
  ) u_addsub (
    .a_i     (add_a),
    .b_i     (add_b),
    .op_i    (add_op),
    .sum_o   (add_sum),
    .carry_o (add_co)
  );

  // operand selection for the shared unit
  always_comb begin
    add_a  = '0;
    add_b  = '0;
    add_op = OP_SUB;
    case (state_q)
      ST_LOOP: begin
        add_a = {1'b0, (x_gt_y ? x_q : y_q)};
        add_b = {1'b0, (x_gt_y ? y_q : x_q)};
      end
      ST_DIV: begin
        add_a = div_shift;
        add_b = {1'b0, g_q};
      end
      ST_MUL: begin
        add_a  = {1'b0, rem_q[W-2:0], 1'b0};
        add_b  = {1'b0, (quo_q[W-1] ? b_q : {W{1'b0}})};
        add_op = OP_ADD;
      end
      default: ;
    endcase
  end

  // once the running product passes the maximum it can only grow
  assign mul_ovf = ovf_q || rem_q[W-1] || add_sum[W];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ((a_m == '0) || (b_m == '0)) ? ST_DONE : ST_STRIP;
        end
      end
      ST_STRIP: begin
        if (x_q[0] || y_q[0]) state_d = ST_ODD;
      end
      ST_ODD: begin
        if (x_q[0]) state_d = ST_LOOP;
      end
      ST_LOOP: begin
        if (y_q == '0) state_d = ST_DIV;
      end
      ST_DIV: begin
        if (cnt_q == '0) state_d = ST_MUL;
      end
      ST_MUL: begin
        if (cnt_q == '0) state_d = ST_DONE;
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath next values
  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    b_d    = b_q;
    g_d    = g_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    twos_d = twos_q;
    cnt_d  = cnt_q;
    ovf_d  = ovf_q;
    gcd_d  = gcd_q;
    lcm_d  = lcm_q;
    lovf_d = lovf_q;
    cop_d  = cop_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          x_d    = a_m;
          y_d    = b_m;
          b_d    = b_m;
          quo_d  = a_m;
          twos_d = '0;
          gcd_d  = a_m | b_m;
          lcm_d  = '0;
          lovf_d = 1'b0;
          cop_d  = ((a_m | b_m) == W'(1));
        end
      end
      ST_STRIP: begin
        if (!(x_q[0] || y_q[0])) begin
          x_d    = x_q >> 1;
          y_d    = y_q >> 1;
          twos_d = twos_q + 1'b1;
        end
      end
      ST_ODD: begin
        if (!x_q[0]) x_d = x_q >> 1;
      end
      ST_LOOP: begin
        if (y_q == '0) begin
          // restore common twos, set up the quotient a / gcd
          g_d   = g_full;
          gcd_d = g_full;
          cop_d = (g_full == W'(1));
          rem_d = '0;
          cnt_d = CNT_LAST;
        end else if (!y_q[0]) begin
          y_d = y_q >> 1;
        end else begin
          if (x_gt_y) x_d = y_q;
          y_d = add_sum[W-1:0];
        end
      end
      ST_DIV: begin
        rem_d = add_co ? add_sum[W-1:0] : div_shift[W-1:0];
        quo_d = {quo_q[W-2:0], add_co};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          rem_d = '0;
          ovf_d = 1'b0;
          cnt_d = CNT_LAST;
        end
      end
      ST_MUL: begin
        rem_d = add_sum[W-1:0];
        quo_d = quo_q << 1;
        ovf_d = mul_ovf;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          lcm_d  = mul_ovf ? {W{1'b1}} : add_sum[W-1:0];
          lovf_d = mul_ovf;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    b_q    <= b_d;
    g_q    <= g_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    twos_q <= twos_d;
    cnt_q  <= cnt_d;
    ovf_q  <= ovf_d;
    gcd_q  <= gcd_d;
    lcm_q  <= lcm_d;
    lovf_q <= lovf_d;
    cop_q  <= cop_d;
  end

  assign busy           = (state_q != ST_IDLE);
  assign done_o         = (state_q == ST_DONE);
  assign gcd_value_o    = IO_W'(gcd_q);
  assign lcm_value_o    = IO_W'(lcm_q);
  assign lcm_overflow_o = lovf_q;
  assign is_coprime_o   = cop_q;

  a_done_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("done without busy");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted item did not raise busy");

  a_done_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy)
    else $error("done strobe longer than one cycle");

  a_ovf_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && lcm_overflow_o) |-> (lcm_value_o == IO_W'({W{1'b1}})))
    else $error("overflow without saturated lcm");

  a_coprime : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (is_coprime_o == (gcd_value_o == IO_W'(1))))
    else $error("coprime flag disagrees with gcd");

endmodule
